### rtl/core/aplp_pkg.sv
// Shared types, constants and lookup functions for the ASCII parameter line parser.
`timescale 1ns / 1ps
`default_nettype none

package aplp_pkg;

    localparam int MAX_LINE_BYTES      = 255;
    localparam int MAX_FRACTION_DIGITS = 8;
    localparam int FRAC_BITS_DEF       = 16;

    localparam int POS_W       = 9;
    localparam int MANT_W      = 40;
    localparam int FD_W        = 4;
    localparam int KEY_W       = 4;
    localparam int POW_W       = 30;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int NUM_KEYS    = 11;
    localparam int QUEUE_DEPTH = 2;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;

    localparam logic [MANT_W-1:0] MANT_MAX   = '1;
    localparam logic [MANT_W-1:0] MANT_LIMIT = (MANT_MAX - 40'd9) / 40'd10;

    // line status codes
    localparam logic [STATUS_W-1:0] LS_BAD     = 2'd0;
    localparam logic [STATUS_W-1:0] LS_LINE    = 2'd1;
    localparam logic [STATUS_W-1:0] LS_UNKNOWN = 2'd2;
    localparam logic [STATUS_W-1:0] LS_PARAM   = 2'd3;

    // characters
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_R     = 8'h72;

    // key words, first byte in the low bits
    localparam logic [31:0] KEY_TABLE [NUM_KEYS] = '{
        32'h2C696870,   // phi,
        32'h2C746874,   // tht,
        32'h2C697370,   // psi,
        32'h2C5F705F,   // _p_,
        32'h2C5F715F,   // _q_,
        32'h2C5F725F,   // _r_,
        32'h2C6F6472,   // rdo,
        32'h2C746C61,   // alt,
        32'h2C5F755F,   // _u_,
        32'h2C5F765F,   // _v_,
        32'h2C647779    // ywd,
    };

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    key;
        logic [MANT_W-1:0]   mantissa;
        logic [FD_W-1:0]     frac_digits;
        logic                negative;
        logic                value_zero;
    } line_rec_t;

    // {hit, index}
    function automatic logic [KEY_W:0] key_lookup(input logic [31:0] kb);
        logic [KEY_W:0] r;
        r = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (kb == KEY_TABLE[k]) begin
                r = {1'b1, KEY_W'(k)};
            end
        end
        return r;
    endfunction

    function automatic logic [POW_W-1:0] pow10(input logic [FD_W-1:0] fd);
        logic [POW_W-1:0] p;
        unique case (fd)
            4'd0:    p = 30'd1;
            4'd1:    p = 30'd10;
            4'd2:    p = 30'd100;
            4'd3:    p = 30'd1000;
            4'd4:    p = 30'd10000;
            4'd5:    p = 30'd100000;
            4'd6:    p = 30'd1000000;
            4'd7:    p = 30'd10000000;
            4'd8:    p = 30'd100000000;
            default: p = 30'd1000000000;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

### rtl/core/aplp_front.sv
// Front end: per-byte line framing, prefix/key capture, count check and value scan.
`timescale 1ns / 1ps
`default_nettype none

module aplp_front
    import aplp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       rx_valid,
    input  wire logic [7:0] rx_byte,
    output logic            push,
    output line_rec_t       push_rec
);

    localparam logic [POS_W-1:0] PRM_POS   = 9'd3;
    localparam logic [POS_W-1:0] KEY_POS   = 9'd7;
    localparam logic [POS_W-1:0] VALUE_POS = 9'd11;
    localparam logic [POS_W-1:0] MAX_POS   = POS_W'(MAX_LINE_BYTES);

    localparam logic [1:0] PH_PRE  = 2'd0;
    localparam logic [1:0] PH_INT  = 2'd1;
    localparam logic [1:0] PH_FRAC = 2'd2;
    localparam logic [1:0] PH_END  = 2'd3;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              prefix_ok_reg, prefix_ok_next;
    logic              prm_ok_reg, prm_ok_next;
    logic [31:0]       key_bytes_reg, key_bytes_next;
    logic [7:0]        last_comma_reg, last_comma_next;
    logic              comma_seen_reg, comma_seen_next;
    logic [7:0]        count_reg, count_next;
    logic [MANT_W-1:0] mant_reg, mant_next;
    logic [FD_W-1:0]   fd_reg, fd_next;
    logic              neg_reg, neg_next;
    logic [1:0]        phase_reg, phase_next;

    logic              in_line;
    logic              is_digit;
    logic              is_space;
    logic              mant_big;
    logic [MANT_W-1:0] mant_x10d;
    logic              int_path;
    logic              frame_ok;
    logic [KEY_W:0]    key_hit;
    logic [1:0]        key_lane;
    logic [7:0]        prefix_char;
    logic [7:0]        prm_char;

    assign in_line   = pos_reg < MAX_POS;
    assign is_digit  = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    assign is_space  = (rx_byte == CH_SPACE) || (rx_byte == CH_TAB) || (rx_byte == CH_VT)
                    || (rx_byte == CH_FF) || (rx_byte == CH_CR);
    assign mant_big  = mant_reg > MANT_LIMIT;
    assign mant_x10d = (mant_reg << 3) + (mant_reg << 1) + MANT_W'(rx_byte[3:0]);
    assign key_lane  = 2'(pos_reg - KEY_POS);

    always_comb begin
        unique case (pos_reg[1:0])
            2'd0:    prefix_char = CH_H;
            2'd1:    prefix_char = CH_I;
            default: prefix_char = CH_COMMA;
        endcase
        unique case (2'(pos_reg - PRM_POS))
            2'd0:    prm_char = CH_P;
            2'd1:    prm_char = CH_R;
            2'd2:    prm_char = CH_M;
            default: prm_char = CH_COMMA;
        endcase
    end

    // line record, valid when a newline is taken
    assign frame_ok = in_line && (pos_reg >= PRM_POS) && prefix_ok_reg && comma_seen_reg
                   && (count_reg == last_comma_reg);
    assign key_hit  = key_lookup(key_bytes_reg);
    assign push     = rx_valid && (rx_byte == CH_NL);

    always_comb begin
        push_rec             = '0;
        push_rec.mantissa    = mant_reg;
        push_rec.frac_digits = fd_reg;
        push_rec.negative    = neg_reg;
        push_rec.value_zero  = last_comma_reg < VALUE_POS[7:0];
        push_rec.key         = key_hit[KEY_W-1:0];
        if (!frame_ok) begin
            push_rec.status = LS_BAD;
        end else if ((pos_reg < KEY_POS) || !prm_ok_reg) begin
            push_rec.status = LS_LINE;
        end else if ((pos_reg >= VALUE_POS) && key_hit[KEY_W]) begin
            push_rec.status = LS_PARAM;
        end else begin
            push_rec.status = LS_UNKNOWN;
        end
    end

    always_comb begin
        pos_next        = pos_reg;
        prefix_ok_next  = prefix_ok_reg;
        prm_ok_next     = prm_ok_reg;
        key_bytes_next  = key_bytes_reg;
        last_comma_next = last_comma_reg;
        comma_seen_next = comma_seen_reg;
        count_next      = count_reg;
        mant_next       = mant_reg;
        fd_next         = fd_reg;
        neg_next        = neg_reg;
        phase_next      = phase_reg;
        int_path        = 1'b0;

        if (rx_valid) begin
            if (rx_byte == CH_NL) begin
                pos_next        = '0;
                prefix_ok_next  = 1'b1;
                prm_ok_next     = 1'b1;
                key_bytes_next  = '0;
                last_comma_next = '0;
                comma_seen_next = 1'b0;
                count_next      = '0;
                mant_next       = '0;
                fd_next         = '0;
                neg_next        = 1'b0;
                phase_next      = PH_PRE;
            end else begin
                if (pos_reg < PRM_POS) begin
                    if (rx_byte != prefix_char) begin
                        prefix_ok_next = 1'b0;
                    end
                end else if (pos_reg < KEY_POS) begin
                    if (rx_byte != prm_char) begin
                        prm_ok_next = 1'b0;
                    end
                end else if (pos_reg < VALUE_POS) begin
                    key_bytes_next[key_lane*8 +: 8] = rx_byte;
                end else if (in_line) begin
                    if (phase_reg == PH_PRE) begin
                        if (is_space) begin
                            phase_next = PH_PRE;
                        end else if ((rx_byte == CH_PLUS) || (rx_byte == CH_MINUS)) begin
                            neg_next   = rx_byte == CH_MINUS;
                            phase_next = PH_INT;
                        end else begin
                            phase_next = PH_INT;
                            int_path   = 1'b1;
                        end
                    end else if (phase_reg == PH_INT) begin
                        int_path = 1'b1;
                    end else if (phase_reg == PH_FRAC) begin
                        if (is_digit) begin
                            if ((fd_reg < FD_W'(MAX_FRACTION_DIGITS)) && !mant_big) begin
                                mant_next = mant_x10d;
                                fd_next   = fd_reg + 1'b1;
                            end
                        end else begin
                            phase_next = PH_END;
                        end
                    end
                    if (int_path) begin
                        if (is_digit) begin
                            mant_next = mant_big ? MANT_MAX : mant_x10d;
                        end else if (rx_byte == CH_DOT) begin
                            phase_next = PH_FRAC;
                        end else begin
                            phase_next = PH_END;
                        end
                    end
                end

                if (in_line) begin
                    if (rx_byte == CH_COMMA) begin
                        last_comma_next = pos_reg[7:0];
                        comma_seen_next = 1'b1;
                        count_next      = '0;
                    end else begin
                        count_next = (count_reg << 3) + (count_reg << 1) + rx_byte - CH_ZERO;
                    end
                    pos_next = pos_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            prefix_ok_reg  <= 1'b1;
            prm_ok_reg     <= 1'b1;
            key_bytes_reg  <= '0;
            last_comma_reg <= '0;
            comma_seen_reg <= 1'b0;
            count_reg      <= '0;
            mant_reg       <= '0;
            fd_reg         <= '0;
            neg_reg        <= 1'b0;
            phase_reg      <= PH_PRE;
        end else begin
            pos_reg        <= pos_next;
            prefix_ok_reg  <= prefix_ok_next;
            prm_ok_reg     <= prm_ok_next;
            key_bytes_reg  <= key_bytes_next;
            last_comma_reg <= last_comma_next;
            comma_seen_reg <= comma_seen_next;
            count_reg      <= count_next;
            mant_reg       <= mant_next;
            fd_reg         <= fd_next;
            neg_reg        <= neg_next;
            phase_reg      <= phase_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/aplp_fifo.sv
// Short queue of finished line records between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module aplp_fifo
    import aplp_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  wire line_rec_t push_rec,
    output logic           full,
    input  wire logic      pop,
    output logic           empty,
    output line_rec_t      head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    line_rec_t        entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = count_reg == CNT_W'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/aplp_back.sv
// Back end: fixed-point conversion by a bit-serial divider and the result register.
`timescale 1ns / 1ps
`default_nettype none

module aplp_back
    import aplp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  empty,
    input  wire line_rec_t             head,
    output logic                       pop,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [STATUS_W-1:0]        out_status,
    output logic [KEY_W-1:0]           out_key,
    output logic signed [VALUE_W-1:0]  out_value,
    output logic                       out_sat
);

    // dividend is (mantissa << FRAC_BITS) + p/2
    localparam int DIV_W = MANT_W + FRAC_BITS + 1;
    localparam int CNT_W = $clog2(DIV_W + 1);
    localparam int QUO_W = VALUE_W + 1;

    localparam logic [1:0] BK_IDLE = 2'd0;
    localparam logic [1:0] BK_DIV  = 2'd1;
    localparam logic [1:0] BK_FIN  = 2'd2;

    localparam logic [QUO_W-1:0] MAG_POS = {2'b00, {(VALUE_W-1){1'b1}}};
    localparam logic [QUO_W-1:0] MAG_NEG = {2'b01, {(VALUE_W-1){1'b0}}};

    logic [1:0]         state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DIV_W-1:0]   dvd_reg, dvd_next;
    logic [POW_W-1:0]   rem_reg, rem_next;
    logic [POW_W-1:0]   div_reg, div_next;
    logic [QUO_W-1:0]   quo_reg, quo_next;
    logic               ovf_reg, ovf_next;
    logic               neg_reg, neg_next;
    logic [KEY_W-1:0]   key_reg, key_next;

    logic                       out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]        out_status_reg, out_status_next;
    logic [KEY_W-1:0]           out_key_reg, out_key_next;
    logic signed [VALUE_W-1:0]  out_value_reg, out_value_next;
    logic                       out_sat_reg, out_sat_next;

    logic [POW_W-1:0]   head_pow;
    logic [POW_W:0]     trial;
    logic               trial_ge;
    logic [QUO_W-1:0]   max_mag;
    logic               sat;
    logic [QUO_W-1:0]   mag;

    assign head_pow = pow10(head.frac_digits);
    assign trial    = {rem_reg, dvd_reg[DIV_W-1]};
    assign trial_ge = trial >= {1'b0, div_reg};
    assign max_mag  = neg_reg ? MAG_NEG : MAG_POS;
    assign sat      = ovf_reg || (quo_reg > max_mag);
    assign mag      = sat ? max_mag : quo_reg;

    assign pop        = (state_reg == BK_IDLE) && !empty && (!out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_key    = out_key_reg;
    assign out_value  = out_value_reg;
    assign out_sat    = out_sat_reg;

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        div_next        = div_reg;
        quo_next        = quo_reg;
        ovf_next        = ovf_reg;
        neg_next        = neg_reg;
        key_next        = key_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_key_next    = out_key_reg;
        out_value_next  = out_value_reg;
        out_sat_next    = out_sat_reg;

        unique case (state_reg)
            BK_IDLE: begin
                if (pop) begin
                    if ((head.status == LS_PARAM) && !head.value_zero) begin
                        dvd_next   = DIV_W'({head.mantissa, {FRAC_BITS{1'b0}}})
                                   + DIV_W'(head_pow >> 1);
                        div_next   = head_pow;
                        rem_next   = '0;
                        quo_next   = '0;
                        ovf_next   = 1'b0;
                        neg_next   = head.negative;
                        key_next   = head.key;
                        cnt_next   = CNT_W'(DIV_W);
                        state_next = BK_DIV;
                    end else begin
                        out_valid_next  = 1'b1;
                        out_status_next = head.status;
                        out_key_next    = (head.status == LS_PARAM) ? head.key : '0;
                        out_value_next  = '0;
                        out_sat_next    = 1'b0;
                    end
                end
            end
            BK_DIV: begin
                rem_next = trial_ge ? POW_W'(trial - {1'b0, div_reg}) : trial[POW_W-1:0];
                quo_next = {quo_reg[QUO_W-2:0], trial_ge};
                ovf_next = ovf_reg | quo_reg[QUO_W-1];
                dvd_next = dvd_reg << 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = BK_FIN;
                end
            end
            BK_FIN: begin
                out_valid_next  = 1'b1;
                out_status_next = LS_PARAM;
                out_key_next    = key_reg;
                out_value_next  = neg_reg ? (~mag[VALUE_W-1:0] + 1'b1) : mag[VALUE_W-1:0];
                out_sat_next    = sat;
                state_next      = BK_IDLE;
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        dvd_reg        <= dvd_next;
        rem_reg        <= rem_next;
        div_reg        <= div_next;
        quo_reg        <= quo_next;
        ovf_reg        <= ovf_next;
        neg_reg        <= neg_next;
        key_reg        <= key_next;
        cnt_reg        <= cnt_next;
        out_status_reg <= out_status_next;
        out_key_reg    <= out_key_next;
        out_value_reg  <= out_value_next;
        out_sat_reg    <= out_sat_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/ascii_param_line_parser_top.sv
// Top level of the ASCII parameter line parser: front end, record queue, back end.
`timescale 1ns / 1ps
`default_nettype none

// Takes received UART bytes, one per transaction, and returns one result per
// newline-terminated line: a status (bad frame, plain valid line, unknown key,
// parameter update) and, for a parameter update, the key number and the value
// in signed fixed point with FRAC_BITS fraction bits plus a saturation flag.
// The front end takes each byte as it is accepted; a newline hands a line
// record to a two-entry queue. The back end turns a parameter update into
// fixed point with a one-bit-per-cycle divider and pops no further record
// until the result is registered; other lines go straight to the result register.
// The input stalls only while the queue is full.
module ascii_param_line_parser_top
    import aplp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]   s_axis_tdata,   // [7:0] rx_byte
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    output logic [OUT_TDATA_W-1:0]       m_axis_tdata,   // [3:0] key_index, [35:4] param_value,
                                                         // [36] value_saturated, [39:37] zero
    output logic [STATUS_W-1:0]          m_axis_tuser    // [1:0] line_status
);

    logic                       rx_valid;
    logic                       q_push;
    line_rec_t                  q_push_rec;
    logic                       q_full;
    logic                       q_pop;
    logic                       q_empty;
    line_rec_t                  q_head;
    logic [STATUS_W-1:0]        out_status;
    logic [KEY_W-1:0]           out_key;
    logic signed [VALUE_W-1:0]  out_value;
    logic                       out_sat;

    assign s_axis_tready = !q_full;
    assign rx_valid      = s_axis_tvalid && s_axis_tready;

    aplp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rx_valid (rx_valid),
        .rx_byte  (s_axis_tdata),
        .push     (q_push),
        .push_rec (q_push_rec)
    );

    aplp_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_rec (q_push_rec),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    aplp_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .empty      (q_empty),
        .head       (q_head),
        .pop        (q_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (out_status),
        .out_key    (out_key),
        .out_value  (out_value),
        .out_sat    (out_sat)
    );

    assign m_axis_tuser = out_status;
    assign m_axis_tdata = {3'b000, out_sat, out_value, out_key};

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("record pushed into full queue");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("record popped from empty queue");

    a_plain_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (out_status != LS_PARAM)) |->
        ((out_key == '0) && (out_value == '0) && !out_sat))
        else $error("non-parameter result carries a value");

    a_sat_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && out_sat) |->
        ((out_value == 32'sh7FFFFFFF) || (out_value == 32'sh80000000)))
        else $error("saturated result not clamped");
`endif

endmodule

`default_nettype wire

### sim/ascii_param_line_parser_top_test.sv
// Testbench for the ASCII parameter line parser: byte stream in, checked line verdicts out.
`timescale 1ns / 1ps

module ascii_param_line_parser_top_test;
    import aplp_pkg::*;

    localparam int FRAC_BITS = FRAC_BITS_DEF;
    localparam int RANDOM_BYTES = 450;
    localparam int RANDOM_LINES = 60;
    localparam int HOLD_AT = 30;
    localparam int HOLD_CYCLES = 300;

    typedef enum logic [1:0] {VP_LEAD, VP_INT, VP_FRAC, VP_DONE} value_phase_e;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    key;
        logic [VALUE_W-1:0]  value;
        logic                sat;
    } line_verdict_t;

    class line_verdict_board;
        line_verdict_t verdict_q[$];
        int            mismatches = 0;
        logic [7:0]    hi_text[3] = '{CH_H, CH_I, CH_COMMA};
        logic [7:0]    prm_text[4] = '{CH_P, CH_R, CH_M, CH_COMMA};

        int           line_pos;
        logic         prefix_ok;
        logic         prm_ok;
        logic [31:0]  key_word;
        logic [7:0]   comma_pos;
        logic         comma_seen;
        logic [7:0]   count_acc;
        logic [MANT_W-1:0] mant;
        int           frac_cnt;
        logic         neg;
        value_phase_e phase;

        function new();
            start_line();
        endfunction

        function void start_line();
            line_pos = 0;
            prefix_ok = 1'b1;
            prm_ok = 1'b1;
            key_word = '0;
            comma_pos = '0;
            comma_seen = 1'b0;
            count_acc = '0;
            mant = '0;
            frac_cnt = 0;
            neg = 1'b0;
            phase = VP_LEAD;
        endfunction

        function void value_char(logic [7:0] b);
            logic is_dig;
            is_dig = (b >= CH_ZERO) && (b <= CH_NINE);
            if (phase == VP_LEAD) begin
                if (b == CH_SPACE || b == CH_TAB || b == CH_VT || b == CH_FF || b == CH_CR)
                    return;
                if (b == CH_PLUS || b == CH_MINUS) begin
                    neg = (b == CH_MINUS);
                    phase = VP_INT;
                    return;
                end
                phase = VP_INT;
            end
            if (phase == VP_INT) begin
                if (is_dig) begin
                    mant = (mant > MANT_LIMIT) ? MANT_MAX
                                               : mant * 40'd10 + 40'(b) - 40'(CH_ZERO);
                end else if (b == CH_DOT) begin
                    phase = VP_FRAC;
                end else begin
                    phase = VP_DONE;
                end
            end else if (phase == VP_FRAC) begin
                if (is_dig) begin
                    if (frac_cnt < MAX_FRACTION_DIGITS && mant <= MANT_LIMIT) begin
                        mant = mant * 40'd10 + 40'(b) - 40'(CH_ZERO);
                        frac_cnt++;
                    end
                end else begin
                    phase = VP_DONE;
                end
            end
        endfunction

        function logic [VALUE_W-1:0] fixed_value(output logic sat);
            bit [63:0] p, ip, rem, maxmag, q;
            int fd;
            fd = (frac_cnt > 9) ? 9 : frac_cnt;
            p = 64'd1;
            for (int i = 0; i < fd; i++) p = p * 64'd10;
            ip = 64'(mant) / p;
            rem = 64'(mant) % p;
            maxmag = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
            sat = 1'b0;
            if (comma_pos < 8'd11)
                return '0;
            if (ip > (64'd1 << (31 - FRAC_BITS))) begin
                q = maxmag;
                sat = 1'b1;
            end else begin
                q = (ip << FRAC_BITS) + (((rem << FRAC_BITS) + p / 64'd2) / p);
                if (q > maxmag) begin
                    q = maxmag;
                    sat = 1'b1;
                end
            end
            if (neg)
                q = 64'd0 - q;
            return q[31:0];
        endfunction

        function void note_byte(logic [7:0] b);
            line_verdict_t r;
            logic sat;
            logic found;
            if (b != CH_NL) begin
                if (line_pos < 3) begin
                    if (b != hi_text[line_pos]) prefix_ok = 1'b0;
                end else if (line_pos < 7) begin
                    if (b != prm_text[line_pos - 3]) prm_ok = 1'b0;
                end else if (line_pos < 11) begin
                    key_word |= 32'(b) << ((line_pos - 7) * 8);
                end else if (line_pos < MAX_LINE_BYTES) begin
                    value_char(b);
                end
                if (line_pos < MAX_LINE_BYTES) begin
                    if (b == CH_COMMA) begin
                        comma_pos = 8'(line_pos);
                        comma_seen = 1'b1;
                        count_acc = '0;
                    end else begin
                        count_acc = 8'(count_acc * 8'd10 + b - CH_ZERO);
                    end
                    line_pos++;
                end
                return;
            end
            r = '0;
            found = 1'b0;
            if (line_pos < MAX_LINE_BYTES && line_pos >= 3 && prefix_ok && comma_seen &&
                count_acc == comma_pos) begin
                if (line_pos < 7 || !prm_ok) begin
                    r.status = LS_LINE;
                end else begin
                    r.status = LS_UNKNOWN;
                    if (line_pos >= 11) begin
                        for (int k = 0; k < NUM_KEYS; k++) begin
                            if (!found && key_word == KEY_TABLE[k]) begin
                                found = 1'b1;
                                r.status = LS_PARAM;
                                r.key = KEY_W'(k);
                                r.value = fixed_value(sat);
                                r.sat = sat;
                            end
                        end
                    end
                end
            end
            verdict_q.push_back(r);
            start_line();
        endfunction

        function void check_result(logic [STATUS_W-1:0] status, logic [KEY_W-1:0] key,
                                   logic [VALUE_W-1:0] value, logic sat);
            line_verdict_t e;
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected result status %0d key %0d value %h sat %0d",
                         $time, status, key, value, sat);
                mismatches++;
                return;
            end
            e = verdict_q.pop_front();
            if (status !== e.status) begin
                $display("%0t: line_status expected %0d got %0d", $time, e.status, status);
                mismatches++;
            end
            if (key !== e.key) begin
                $display("%0t: key_index expected %0d got %0d", $time, e.key, key);
                mismatches++;
            end
            if (value !== e.value) begin
                $display("%0t: param_value expected %h got %h", $time, e.value, value);
                mismatches++;
            end
            if (sat !== e.sat) begin
                $display("%0t: value_saturated expected %0d got %0d", $time, e.sat, sat);
                mismatches++;
            end
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]    m_axis_tuser;

    line_verdict_board verdicts;
    logic [7:0] line_buf[$];
    logic [7:0] blanks[5] = '{CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR};
    int  bytes_sent = 0;
    int  results_seen = 0;
    int  long_lines = 0;
    logic steady_tx = 1'b0;
    logic steady_rx = 1'b0;

    ascii_param_line_parser_top #(.FRAC_BITS(FRAC_BITS)) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void put_char(logic [7:0] c);
        line_buf.push_back(c);
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endfunction

    function automatic void put_digit();
        put_char(8'(CH_ZERO + $urandom_range(0, 9)));
    endfunction

    // final comma at the current position, followed by that position modulo 256 in decimal
    function automatic void close_line();
        int at;
        at = line_buf.size();
        put_char(CH_COMMA);
        put_text($sformatf("%0d", at % 256));
        put_char(CH_NL);
    endfunction

    function automatic void start_param(int k);
        put_text("Hi,prm,");
        for (int i = 0; i < 4; i++) put_char(KEY_TABLE[k][8*i +: 8]);
    endfunction

    function automatic void put_value();
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 2)) put_char(blanks[$urandom_range(0, 4)]);
        case ($urandom_range(0, 2))
            1: put_char(CH_PLUS);
            2: put_char(CH_MINUS);
            default: ;
        endcase
        if ($urandom_range(0, 9) == 0)
            put_text($urandom_range(0, 1) ? "32767" : "32768");
        else
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(6, 16) : $urandom_range(0, 5))
                put_digit();
        if ($urandom_range(0, 9) < 7) begin
            put_char(CH_DOT);
            repeat ($urandom_range(0, 11)) put_digit();
        end
        if ($urandom_range(0, 19) == 0)
            put_text("e3");
    endfunction

    task automatic send_byte(logic [7:0] value);
        int gap;
        gap = steady_tx ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= value;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        verdicts.note_byte(value);
        bytes_sent++;
    endtask

    task automatic send_line();
        steady_tx = ($urandom_range(0, 3) == 0);
        foreach (line_buf[i]) send_byte(line_buf[i]);
        line_buf.delete();
    endtask

    task automatic long_line(int comma_at);
        put_text("Hi,");
        while (line_buf.size() < comma_at) put_char(8'($urandom_range(8'h61, 8'h7A)));
        close_line();
        send_line();
    endtask

    task automatic random_line();
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 55) begin
            if ($urandom_range(0, 9) == 0) begin
                put_text("Hi,prm,");
                repeat (3) put_char(8'($urandom_range(0, 255)));
                put_char($urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255)) : CH_COMMA);
            end else begin
                start_param($urandom_range(0, NUM_KEYS - 1));
            end
            put_value();
            if ($urandom_range(0, 5) == 0) begin
                put_char(CH_COMMA);
                repeat ($urandom_range(0, 3)) put_char(8'($urandom_range(8'h21, 8'h7E)));
            end
            close_line();
        end else if (kind < 80) begin
            put_text("Hi,");
            repeat ($urandom_range(0, 12)) put_char(8'($urandom_range(0, 255)));
            close_line();
        end else if (kind < 95) begin
            repeat ($urandom_range(0, 20)) put_char(8'($urandom_range(0, 255)));
            put_char(CH_NL);
        end else if (kind < 98 || long_lines >= 2) begin
            put_text($urandom_range(0, 1) ? "Hi,prm" : "Hi,prm,ph");
            close_line();
        end else begin
            long_lines++;
            long_line($urandom_range(240, 270));
            return;
        end
        if ($urandom_range(0, 9) == 0 && line_buf.size() > 1)
            line_buf[$urandom_range(0, line_buf.size() - 2)] = 8'($urandom_range(0, 255));
        send_line();
    endtask

    initial begin
        int random_start;
        int random_lines;
        verdicts = new();
        aresetn <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        start_param(0);  put_text("0");                close_line(); send_line();
        start_param(1);  put_text("-0.5");             close_line(); send_line();
        start_param(2);  put_text("+123.25");          close_line(); send_line();
        start_param(3);  put_text("32767.99999");      close_line(); send_line();
        start_param(4);  put_text("32768");            close_line(); send_line();
        start_param(5);  put_text("-32768");           close_line(); send_line();
        start_param(6);  put_text("-32768.00001");     close_line(); send_line();
        start_param(7);  put_text("123456789012345");  close_line(); send_line();
        start_param(8);  put_text(" \t-1.123456789012"); close_line(); send_line();
        start_param(9);  put_text("1e5");              close_line(); send_line();
        start_param(10); put_char(CH_VT); put_char(CH_FF); put_char(CH_CR);
        put_text(".5");                                close_line(); send_line();
        start_param(0);  put_text("2.5,junk");         close_line(); send_line();
        start_param(1);  put_text("10"); put_char(CH_NL); send_line();
        put_text("Hi,prm,xyz,");                       close_line(); send_line();
        put_text("Hi,prm");                            close_line(); send_line();
        put_text("Hi,prx,phi,5");                      close_line(); send_line();
        put_text("Hi");                                close_line(); send_line();
        put_text("Hi,A"); put_char(8'h88); put_char(CH_NL); send_line();
        put_text("Ho");                                close_line(); send_line();
        put_text("Hi,5"); put_char(CH_NL);             send_line();
        put_text("Hi");   put_char(CH_NL);             send_line();
        put_char(CH_NL);                               send_line();
        long_line(250);
        long_line(251);
        long_line(280);

        random_start = bytes_sent;
        random_lines = 0;
        while (bytes_sent - random_start < RANDOM_BYTES || random_lines < RANDOM_LINES) begin
            random_line();
            random_lines++;
        end
        s_axis_tvalid <= 1'b0;

        while (verdicts.pending() > 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (verdicts.mismatches == 0 && verdicts.pending() == 0)
            $display("ascii_param_line_parser_top_test: PASS");
        else
            $display("ascii_param_line_parser_top_test: FAIL");
        $finish;
    end

    initial begin
        int stall;
        logic held;
        held = 1'b0;
        m_axis_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (results_seen == HOLD_AT && !held) begin
                held = 1'b1;
                stall = HOLD_CYCLES;
            end else begin
                stall = steady_rx ? 0 : $urandom_range(0, 4);
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(posedge aclk);
            while (!m_axis_tvalid) @(posedge aclk);
            verdicts.check_result(m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[35:4],
                                  m_axis_tdata[36]);
            results_seen++;
            if (results_seen % 16 == 0)
                steady_rx = ($urandom_range(0, 3) == 0);
        end
    end

    initial begin
        #3_000_000;
        $display("ascii_param_line_parser_top_test: FAIL");
        $finish;
    end

endmodule

### files.f
rtl/core/aplp_pkg.sv
rtl/core/aplp_front.sv
rtl/core/aplp_fifo.sv
rtl/core/aplp_back.sv
rtl/core/ascii_param_line_parser_top.sv
sim/ascii_param_line_parser_top_test.sv
